FILE: rtl/spr_pkg.sv
// ----------------------------------------------------------------------------
// spr_pkg
// Shared types and constants of the sprite pixel rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package spr_pkg;

    // graphics rom geometry
    localparam int GFX_ROM_BYTES = 5242880;
    localparam int ROM_AW        = $clog2(GFX_ROM_BYTES);
    localparam int NIB_W         = 24;
    localparam logic [NIB_W-1:0] NIB_WRAP = NIB_W'(2 * GFX_ROM_BYTES);

    // signed destination coordinate width before clipping
    localparam int DW  = 19;
    // global offset width after the bias is removed
    localparam int GW  = 18;

    localparam logic [GW-1:0] GX_BIAS = GW'(16'h0184);
    localparam logic [GW-1:0] GY_BIAS = GW'(16'h01f1);

    // queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // stream widths
    localparam int IN_DW  = 96;
    localparam int OUT_DW = 32;
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 16;

    // request actions
    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_LOAD  = 2'd1;
    localparam logic [1:0] ACT_STEP  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_GLOBAL_X = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_GLOBAL_Y = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_CLIP_MINX = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_CLIP_MAXX = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_CLIP_MINY = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_CLIP_MAXY = 3'd5;

    typedef enum logic [1:0] {
        K_NONE  = 2'd0,
        K_WRITE = 2'd1,
        K_STEP  = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind                 kind;
        logic [ROM_AW-1:0]     addr;
        logic [7:0]            wbyte;
        logic                  hi_nib;
        logic signed [DW-1:0]  dx;
        logic signed [DW-1:0]  dy;
        logic [5:0]            pen;
        logic [1:0]            prio;
        logic                  done;
    } t_cmd;

    typedef struct packed {
        logic [GW-1:0] gx;
        logic [GW-1:0] gy;
        logic [9:0]    min_x;
        logic [9:0]    max_x;
        logic [9:0]    min_y;
        logic [9:0]    max_y;
    } t_cfg;

endpackage

`default_nettype wire

FILE: rtl/spr_front.sv
// ----------------------------------------------------------------------------
// spr_front
// Accepts requests, walks the active sprite and issues rom commands.
// ----------------------------------------------------------------------------
`default_nettype none

module spr_front import spr_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [1:0]       i_action,
    input  wire logic [IN_DW-1:0] i_data,
    input  wire t_cfg             i_cfg,
    output logic                  o_cmd_valid,
    input  wire logic             i_cmd_ready,
    output t_cmd                  o_cmd
);

    logic [15:0]      r_w0, r_w2, r_w3;
    logic [7:0]       r_col, r_row;
    logic [NIB_W-1:0] r_off;
    logic             r_active;

    logic [ROM_AW-1:0] f_addr;
    logic [7:0]        f_byte;
    logic [15:0]       f_w0, f_w1, f_w2, f_w3;
    logic              acc, skip;
    logic [7:0]        width_m1, height_m1, xcnt, ycnt;
    logic [NIB_W-1:0]  off_eff;
    logic              last_col, last_row;

    assign f_addr = i_data[22:0];
    assign f_byte = i_data[30:23];
    assign f_w0   = i_data[46:31];
    assign f_w1   = i_data[62:47];
    assign f_w2   = i_data[78:63];
    assign f_w3   = i_data[94:79];

    assign o_ready     = i_cmd_ready;
    assign o_cmd_valid = i_valid;
    assign acc         = i_valid && i_cmd_ready;

    // ram test pattern or zero size means nothing to draw
    assign skip = (f_w3 == f_w0) || (f_w2[15:12] == 4'd0) || (f_w3[15:12] == 4'd0);

    assign width_m1  = {r_w2[15:12], 4'b0} - 8'd1;
    assign height_m1 = {r_w3[15:12], 4'b0} - 8'd1;
    assign xcnt      = r_w0[7] ? width_m1 - r_col : r_col;
    assign ycnt      = r_w0[6] ? height_m1 - r_row : r_row;
    assign off_eff   = (r_off >= NIB_WRAP) ? '0 : r_off;
    assign last_col  = (r_col == width_m1);
    assign last_row  = (r_row == height_m1);

    always_comb begin
        o_cmd        = '0;
        o_cmd.kind   = K_NONE;
        case (i_action)
            ACT_WRITE: begin
                if ({1'b0, f_addr} < (ROM_AW + 1)'(GFX_ROM_BYTES)) begin
                    o_cmd.kind = K_WRITE;
                end
                o_cmd.addr  = f_addr;
                o_cmd.wbyte = f_byte;
            end
            ACT_LOAD: begin
                o_cmd.prio = f_w0[15:14];
                o_cmd.done = skip;
            end
            ACT_STEP: begin
                if (r_active) begin
                    o_cmd.kind   = K_STEP;
                    o_cmd.addr   = off_eff[NIB_W-1:1];
                    o_cmd.hi_nib = off_eff[0];
                    o_cmd.dx     = {{(DW-10){r_w2[9]}}, r_w2[9:0]}
                                 + {{(DW-8){1'b0}}, xcnt}
                                 - {{(DW-GW){i_cfg.gx[GW-1]}}, i_cfg.gx};
                    o_cmd.dy     = {{(DW-10){r_w3[9]}}, r_w3[9:0]}
                                 + {{(DW-8){1'b0}}, ycnt}
                                 - {{(DW-GW){i_cfg.gy[GW-1]}}, i_cfg.gy};
                    o_cmd.pen    = r_w0[13:8];
                    o_cmd.prio   = r_w0[15:14];
                    o_cmd.done   = last_col && last_row;
                end
            end
            default: begin
                o_cmd.kind = K_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w0     <= '0;
            r_w2     <= '0;
            r_w3     <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_off    <= '0;
            r_active <= 1'b0;
        end else if (acc) begin
            if (i_action == ACT_LOAD) begin
                r_w0     <= f_w0;
                r_w2     <= f_w2;
                r_w3     <= f_w3;
                r_col    <= '0;
                r_row    <= '0;
                r_off    <= {f_w1, 8'b0};
                r_active <= !skip;
            end else if (i_action == ACT_STEP && r_active) begin
                r_off <= off_eff + NIB_W'(1);
                if (last_col) begin
                    r_col <= '0;
                    if (last_row) begin
                        r_row    <= '0;
                        r_active <= 1'b0;
                    end else begin
                        r_row <= r_row + 8'd1;
                    end
                end else begin
                    r_col <= r_col + 8'd1;
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/spr_queue.sv
// ----------------------------------------------------------------------------
// spr_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module spr_queue import spr_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_cmd i_cmd,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_cmd      o_cmd
);

    t_cmd            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp, r_rp;
    logic [Q_AW:0]   r_cnt;
    logic            push, pop;

    assign o_ready = (r_cnt != (Q_AW + 1)'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + Q_AW'(1);
            end
            if (pop) begin
                r_rp <= r_rp + Q_AW'(1);
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + (Q_AW + 1)'(1);
                2'b01:   r_cnt <= r_cnt - (Q_AW + 1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/spr_back.sv
// ----------------------------------------------------------------------------
// spr_back
// Graphics rom, nibble fetch, clipping and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module spr_back import spr_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire t_cmd              i_cmd,
    input  wire t_cfg              i_cfg,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic                   o_pixel_valid,
    output logic                   o_done,
    output logic [OUT_DW-1:0]      o_data
);

    logic [7:0] r_rom [GFX_ROM_BYTES];
    logic [7:0] r_rd;

    logic       r_s1_valid;
    t_cmd       r_s1;

    logic              r_o_valid;
    logic              r_o_pix;
    logic              r_o_done;
    logic [OUT_DW-1:0] r_o_data;

    logic       adv, pop;
    logic [3:0] pix;
    logic       in_clip;
    logic       n_pix;

    // whole pipeline moves when the output slot is free or being taken
    assign adv     = !r_o_valid || i_ready;
    assign pop     = adv && i_valid;
    assign o_ready = adv;

    always_ff @(posedge i_clk) begin
        if (pop && i_cmd.kind == K_WRITE) begin
            r_rom[i_cmd.addr] <= i_cmd.wbyte;
        end
        if (pop && i_cmd.kind == K_STEP) begin
            r_rd <= r_rom[i_cmd.addr];
        end
    end

    assign pix = r_s1.hi_nib ? r_rd[7:4] : r_rd[3:0];
    assign in_clip = (r_s1.dx >= $signed({{(DW-10){1'b0}}, i_cfg.min_x}))
                  && (r_s1.dx <= $signed({{(DW-10){1'b0}}, i_cfg.max_x}))
                  && (r_s1.dy >= $signed({{(DW-10){1'b0}}, i_cfg.min_y}))
                  && (r_s1.dy <= $signed({{(DW-10){1'b0}}, i_cfg.max_y}));
    assign n_pix = (r_s1.kind == K_STEP) && (pix != 4'd0) && in_clip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= i_valid;
            r_o_valid  <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_s1 <= i_cmd;
        end
        if (adv && r_s1_valid) begin
            r_o_pix  <= n_pix;
            r_o_done <= r_s1.done;
            r_o_data <= n_pix ? {r_s1.prio, r_s1.pen, pix, r_s1.dy[9:0], r_s1.dx[9:0]}
                              : {r_s1.prio, 30'b0};
        end
    end

    assign o_valid       = r_o_valid;
    assign o_pixel_valid = r_o_pix;
    assign o_done        = r_o_done;
    assign o_data        = r_o_data;

endmodule

`default_nettype wire

FILE: rtl/sprite_pixel_rasterizer.sv
// ----------------------------------------------------------------------------
// sprite_pixel_rasterizer
// 4bpp sprite rasterizer with a byte-loaded graphics rom.
// ----------------------------------------------------------------------------
// Takes one request per clock while the queue has room and returns exactly
// one result per request, in order, through the queue, the rom stage and the
// output register; sustained rate is one request per cycle while the output
// is not stalled, set by the single rom port that serves either one byte
// write or one nibble fetch a cycle. A four-entry queue separates the sprite
// walker from the rom/clip pipeline so either side can stall alone. Rom
// contents are undefined until written and need no clearing after reset.
// Configuration must only be written while no result is outstanding.
`default_nettype none

module sprite_pixel_rasterizer import spr_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // request stream
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    // rom_address, rom_byte, attr_word0, attr_word1, attr_word2, attr_word3
    input  wire logic [IN_DW-1:0]  i_s_tdata,
    // action
    input  wire logic [1:0]        i_s_tuser,
    // result stream
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    // pixel_x, pixel_y, colour, sprite_priority
    output logic [OUT_DW-1:0]      o_m_tdata,
    // pixel_valid
    output logic                   o_m_tuser,
    // sprite_done
    output logic                   o_m_tlast,
    // configuration writes
    input  wire logic              i_cfg_we,
    input  wire logic [CFG_AW-1:0] i_cfg_idx,
    input  wire logic [CFG_DW-1:0] i_cfg_data
);

    t_cfg r_cfg;
    t_cmd front_cmd, queue_cmd;
    logic front_valid, front_ready, queue_valid, back_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gx    <= '0;
            r_cfg.gy    <= '0;
            r_cfg.min_x <= 10'd0;
            r_cfg.max_x <= 10'd319;
            r_cfg.min_y <= 10'd0;
            r_cfg.max_y <= 10'd223;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GLOBAL_X:  r_cfg.gx    <= {2'b0, i_cfg_data} - GX_BIAS;
                CFG_GLOBAL_Y:  r_cfg.gy    <= {2'b0, i_cfg_data} - GY_BIAS;
                CFG_CLIP_MINX: r_cfg.min_x <= i_cfg_data[9:0];
                CFG_CLIP_MAXX: r_cfg.max_x <= i_cfg_data[9:0];
                CFG_CLIP_MINY: r_cfg.min_y <= i_cfg_data[9:0];
                CFG_CLIP_MAXY: r_cfg.max_y <= i_cfg_data[9:0];
                default:       r_cfg       <= r_cfg;
            endcase
        end
    end

    spr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_action    (i_s_tuser),
        .i_data      (i_s_tdata),
        .i_cfg       (r_cfg),
        .o_cmd_valid (front_valid),
        .i_cmd_ready (front_ready),
        .o_cmd       (front_cmd)
    );

    spr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (front_ready),
        .i_cmd   (front_cmd),
        .o_valid (queue_valid),
        .i_ready (back_ready),
        .o_cmd   (queue_cmd)
    );

    spr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (queue_valid),
        .o_ready       (back_ready),
        .i_cmd         (queue_cmd),
        .i_cfg         (r_cfg),
        .o_valid       (o_m_tvalid),
        .i_ready       (i_m_tready),
        .o_pixel_valid (o_m_tuser),
        .o_done        (o_m_tlast),
        .o_data        (o_m_tdata)
    );

    // a written pixel is never transparent
    a_pix_opaque: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata[23:20] != 4'd0)
        else $error("transparent pixel written");

    // a written pixel lies inside the clip window
    a_pix_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |->
            o_m_tdata[9:0] >= r_cfg.min_x && o_m_tdata[9:0] <= r_cfg.max_x &&
            o_m_tdata[19:10] >= r_cfg.min_y && o_m_tdata[19:10] <= r_cfg.max_y)
        else $error("pixel outside clip window");

    // no pixel means zero position and colour
    a_nopix_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata[29:0] == 30'd0)
        else $error("stray pixel fields");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

`default_nettype wire

FILE: tb/sv/tb_sprite_pixel_rasterizer.sv
// ----------------------------------------------------------------------------
// tb_sprite_pixel_rasterizer
// Streams rom writes, sprite loads and pixel steps into the rasterizer and
// checks every result against an in-order prediction of the pixel walk.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sprite_pixel_rasterizer;
    import spr_pkg::*;

    localparam int unsigned ROM_BYTES  = GFX_ROM_BYTES;
    localparam logic [23:0] NIB_LIMIT  = 24'(2 * ROM_BYTES);
    localparam logic [15:0] LAST_TILE  = 16'(ROM_BYTES / 128 - 1);
    localparam int unsigned WRAP_TILE  = ROM_BYTES / 128;
    localparam int          QUIET_MAX  = 2000;
    localparam int          PHASE_ITEMS = 1;

    typedef struct {
        logic [1:0]  action;
        logic [22:0] addr;
        logic [7:0]  rbyte;
        logic [15:0] w0;
        logic [15:0] w1;
        logic [15:0] w2;
        logic [15:0] w3;
    } t_req;

    typedef struct {
        bit       valid;
        bit [9:0] px;
        bit [9:0] py;
        bit [9:0] colour;
        bit [1:0] prio;
        bit       done;
    } t_pix;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic [IN_DW-1:0]  s_tdata = '0;
    logic [1:0]        s_tuser = ACT_WRITE;
    logic              m_tready = 1'b0;
    logic              cfg_we = 1'b0;
    logic [CFG_AW-1:0] cfg_idx = CFG_GLOBAL_X;
    logic [CFG_DW-1:0] cfg_data = '0;
    wire               o_s_tready;
    wire               o_m_tvalid;
    wire [OUT_DW-1:0]  o_m_tdata;
    wire               o_m_tuser;
    wire               o_m_tlast;

    sprite_pixel_rasterizer DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // pending requests, expected pixels
    t_req pending[$];
    t_pix exp_pixels[$];
    int   queued = 0;
    int   errors = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;

    // shadow of the configuration registers
    logic [15:0] ofs_x_raw = 16'h0184;
    logic [15:0] ofs_y_raw = 16'h01F1;
    logic [9:0]  win_x_lo = 10'd0;
    logic [9:0]  win_x_hi = 10'd319;
    logic [9:0]  win_y_lo = 10'd0;
    logic [9:0]  win_y_hi = 10'd223;

    // sprite walker state
    bit [7:0]    rom_img [int unsigned];
    logic [15:0] spr_w0 = '0, spr_w2 = '0, spr_w3 = '0;
    int unsigned spr_col = 0, spr_row = 0;
    logic [23:0] spr_nib = '0;
    bit          spr_live = 1'b0;

    function automatic t_pix raster_step(input t_req r);
        t_pix        o;
        int unsigned wid, hgt, xc, yc, byte_ix;
        int          dx, dy;
        bit [7:0]    b;
        bit [3:0]    nib;
        o = '{default: '0};
        case (r.action)
            ACT_WRITE: begin
                if (r.addr < ROM_BYTES) rom_img[r.addr] = r.rbyte;
            end
            ACT_LOAD: begin
                spr_w0  = r.w0;
                spr_w2  = r.w2;
                spr_w3  = r.w3;
                spr_col = 0;
                spr_row = 0;
                spr_nib = {r.w1, 8'h00};
                o.prio  = r.w0[15:14];
                // ram test pattern and zero-sized sprites are dropped at once
                if (r.w3 == r.w0 || r.w2[15:12] == 0 || r.w3[15:12] == 0) begin
                    spr_live = 1'b0;
                    o.done   = 1'b1;
                end else begin
                    spr_live = 1'b1;
                end
            end
            ACT_STEP: begin
                if (spr_live) begin
                    wid = spr_w2[15:12] * 16;
                    hgt = spr_w3[15:12] * 16;
                    xc  = spr_w0[7] ? wid - 1 - spr_col : spr_col;
                    yc  = spr_w0[6] ? hgt - 1 - spr_row : spr_row;
                    dx  = int'($signed(spr_w2[9:0])) + int'(xc)
                          - (int'(ofs_x_raw) - 32'sh184);
                    dy  = int'($signed(spr_w3[9:0])) + int'(yc)
                          - (int'(ofs_y_raw) - 32'sh1F1);
                    o.prio = spr_w0[15:14];
                    if (spr_nib >= NIB_LIMIT) spr_nib = '0;
                    byte_ix = 32'(spr_nib[23:1]);
                    b   = rom_img.exists(byte_ix) ? rom_img[byte_ix] : 8'h00;
                    nib = spr_nib[0] ? b[7:4] : b[3:0];
                    spr_nib = spr_nib + 24'd1;
                    if (nib != 0 && dx >= int'(win_x_lo) && dx <= int'(win_x_hi) &&
                        dy >= int'(win_y_lo) && dy <= int'(win_y_hi)) begin
                        o.valid  = 1'b1;
                        o.px     = dx[9:0];
                        o.py     = dy[9:0];
                        o.colour = {spr_w0[13:8], nib};
                    end
                    spr_col++;
                    if (spr_col >= wid) begin
                        spr_col = 0;
                        spr_row++;
                        if (spr_row >= hgt) begin
                            spr_row  = 0;
                            spr_live = 1'b0;
                            o.done   = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    // request driver
    t_req cur_req;
    int   send_gap = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_tvalid && o_s_tready) begin
                exp_pixels.push_back(raster_step(cur_req));
            end
            if (!(s_tvalid && !o_s_tready)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending.size() != 0 && $urandom_range(99) < send_idle_pct) begin
                    send_gap = $urandom_range(8);
                    s_tvalid <= 1'b0;
                end else if (pending.size() != 0) begin
                    cur_req = pending.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {1'b0, cur_req.w3, cur_req.w2, cur_req.w1, cur_req.w0,
                                 cur_req.rbyte, cur_req.addr};
                    s_tuser  <= cur_req.action;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    t_pix want;
    int   recv_stall = 0;
    bit   long_hold_done = 1'b0;

    task automatic check_field(input string what, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && m_tready) begin
                if (exp_pixels.size() == 0) begin
                    errors++;
                    $display("%0t: result with nothing expected, expected none, actual %h/%b/%b",
                             $time, o_m_tdata, o_m_tuser, o_m_tlast);
                end else begin
                    want = exp_pixels.pop_front();
                    check_field("pixel_valid", want.valid, o_m_tuser);
                    check_field("pixel_x", want.px, o_m_tdata[9:0]);
                    check_field("pixel_y", want.py, o_m_tdata[19:10]);
                    check_field("colour", want.colour, o_m_tdata[29:20]);
                    check_field("sprite_priority", want.prio, o_m_tdata[31:30]);
                    check_field("sprite_done", want.done, o_m_tlast);
                end
            end
            // one long hold-off while plenty of requests wait, to back up the input
            if (!long_hold_done && pending.size() > 40) begin
                long_hold_done = 1'b1;
                recv_stall = 80;
            end
            if (recv_stall > 0) begin
                recv_stall--;
                m_tready <= 1'b0;
            end else if ($urandom_range(99) < recv_idle_pct) begin
                recv_stall = $urandom_range(8);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_tvalid && o_s_tready) || (o_m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_MAX) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // stimulus
    task automatic push_write(input logic [22:0] addr, input logic [7:0] b);
        t_req r;
        r = '{action: ACT_WRITE, addr: addr, rbyte: b, w0: 16'($urandom),
              w1: 16'($urandom), w2: 16'($urandom), w3: 16'($urandom)};
        pending.push_back(r);
        queued++;
    endtask

    task automatic push_load(input logic [15:0] w0, input logic [15:0] w1,
                             input logic [15:0] w2, input logic [15:0] w3);
        t_req r;
        r = '{action: ACT_LOAD, addr: 23'($urandom), rbyte: 8'($urandom), w0: w0, w1: w1,
              w2: w2, w3: w3};
        pending.push_back(r);
        queued++;
    endtask

    // steps, with a stray rom rewrite or out-of-range write now and then
    task automatic push_steps(input int n);
        t_req r;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(19) == 0) begin
                case ($urandom_range(2))
                    0: push_write(23'($urandom_range(127)), 8'($urandom));
                    1: push_write(23'($urandom_range(ROM_BYTES - 1, ROM_BYTES - 128)),
                                  8'($urandom));
                    default: push_write(23'($urandom_range(23'h7FFFFF, ROM_BYTES)),
                                        8'($urandom));
                endcase
            end
            r = '{action: ACT_STEP, addr: 23'($urandom), rbyte: 8'($urandom),
                  w0: 16'($urandom), w1: 16'($urandom), w2: 16'($urandom),
                  w3: 16'($urandom)};
            pending.push_back(r);
            queued++;
        end
    endtask

    // only tile 0, the last tile and tiles past the wrap are backed by written rom
    task automatic push_random_sprite();
        logic [15:0] w0, w1, w2, w3;
        int unsigned reach;
        w0 = 16'($urandom);
        w2 = 16'($urandom);
        w3 = 16'($urandom);
        case ($urandom_range(2))
            0: begin
                w1 = 16'h0000;
                reach = 256;
            end
            1: begin
                w1 = LAST_TILE;
                reach = 512;
            end
            default: begin
                w1 = 16'($urandom_range(16'hFFFF, WRAP_TILE));
                reach = 256;
            end
        endcase
        case ($urandom_range(9))
            0: w3 = w0;
            1: w2[15:12] = 4'h0;
            2: w3[15:12] = 4'h0;
            default: ;
        endcase
        push_load(w0, w1, w2, w3);
        push_steps(($urandom_range(4) == 0) ? $urandom_range(reach) : $urandom_range(40));
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        case (idx)
            CFG_GLOBAL_X:  ofs_x_raw = val;
            CFG_GLOBAL_Y:  ofs_y_raw = val;
            CFG_CLIP_MINX: win_x_lo = val[9:0];
            CFG_CLIP_MAXX: win_x_hi = val[9:0];
            CFG_CLIP_MINY: win_y_lo = val[9:0];
            CFG_CLIP_MAXY: win_y_hi = val[9:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        @(negedge i_clk);
        while (pending.size() != 0 || s_tvalid || exp_pixels.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    initial begin
        logic [15:0] phase_cfg [7][6];
        int          send_pct [7];
        int          recv_pct [7];
        int          start;
        logic [7:0]  b;
        logic [15:0] w0, w2, w3;

        phase_cfg[1] = '{16'h0184, 16'h01F1, 16'd0, 16'd1023, 16'd0, 16'd1023};
        phase_cfg[2] = '{16'h0000, 16'h0000, 16'd100, 16'd700, 16'd50, 16'd600};
        phase_cfg[3] = '{16'h01C4, 16'h01D1, 16'd0, 16'd319, 16'd0, 16'd223};
        phase_cfg[4] = '{16'hFFFF, 16'hFFFF, 16'd1023, 16'd0, 16'd1023, 16'd0};
        phase_cfg[5] = '{16'($urandom_range(16'h0284, 16'h0084)),
                         16'($urandom_range(16'h02F1, 16'h00F1)),
                         16'($urandom_range(200)), 16'($urandom_range(1023, 200)),
                         16'($urandom_range(200)), 16'($urandom_range(1023, 200))};
        phase_cfg[6] = '{16'h0184, 16'h01F1, 16'd0, 16'd319, 16'd0, 16'd223};
        send_pct = '{15, 0, 30, 10, 25, 20, 0};
        recv_pct = '{15, 0, 10, 40, 25, 30, 0};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < 7; ph++) begin
            if (ph > 0) begin
                drain();
                for (int k = 0; k < 6; k++)
                    write_reg(k[CFG_AW-1:0], phase_cfg[ph][k]);
                @(posedge i_clk);
                cfg_we <= 1'b0;
                @(negedge i_clk);
            end
            send_idle_pct = send_pct[ph];
            recv_idle_pct = recv_pct[ph];

            if (ph == 0) begin
                // no sprite yet, out-of-range writes, empty and skipped loads
                push_steps(1);
                push_write(23'h7FFFFF, 8'hFF);
                push_write(23'(ROM_BYTES), 8'h5A);
                push_load(16'hC0C0, 16'h0000, 16'h01FF, 16'h1000);
                push_load(16'h4000, 16'h0000, 16'h1000, 16'h0000);
                push_load(16'h91C0, 16'h0000, 16'h1000, 16'h91C0);
                push_steps(1);
                // back tile 0 and the last tile before any fetch
                push_write(23'd0, 8'hFF);
                push_write(23'd1, 8'h00);
                for (int a = 2; a < 128; a++) begin
                    b = 8'($urandom);
                    if ($urandom_range(3) == 0) b[3:0] = 4'h0;
                    if ($urandom_range(3) == 0) b[7:4] = 4'h0;
                    push_write(a[22:0], b);
                end
                for (int a = ROM_BYTES - 128; a < ROM_BYTES; a++) begin
                    b = 8'($urandom);
                    if ($urandom_range(3) == 0) b[3:0] = 4'h0;
                    if ($urandom_range(3) == 0) b[7:4] = 4'h0;
                    push_write(a[22:0], b);
                end
                push_load(16'hFF00, 16'h0000, 16'h1000, 16'h1000);
                push_steps(4);
                push_load(16'h40C0, 16'h0000, 16'h13FF, 16'h1000);
                push_steps(4);
                // start nibble past the wrap limit fetches from zero
                push_load(16'h8A40, 16'hFFFF, 16'hF010, 16'hF020);
                push_steps(3);
            end
            if (ph == 1) begin
                // one full 16x16 sprite through to its last pixel
                w0 = 16'($urandom);
                w2 = {4'h1, 2'b00, 10'($urandom)};
                w3 = {4'h1, 2'b00, 10'($urandom)};
                if (w3 == w0) w0[0] = ~w0[0];
                push_load(w0, 16'h0000, w2, w3);
                push_steps(259);
            end
            if (ph == 3) begin
                // last tile, wide enough that the fetch wraps to rom start
                w0 = 16'($urandom);
                w2 = {4'h2, 2'b00, 10'($urandom)};
                w3 = {4'($urandom_range(15, 1)), 2'b00, 10'($urandom)};
                if (w3 == w0) w0[0] = ~w0[0];
                push_load(w0, LAST_TILE, w2, w3);
                push_steps(270);
            end
            start = queued;
            while (queued - start < PHASE_ITEMS)
                push_random_sprite();
        end

        drain();
        repeat (10) @(negedge i_clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
